@@ src/c2d_pkg.sv @@
// ----------------------------------------------------------------------------
// c2d_pkg
// shared types and constants of the streaming 2d convolution unit
// ----------------------------------------------------------------------------
package c2d_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 36;
  localparam int TAP_W    = 8;
  localparam int DIM_W    = 11;
  localparam int REG_W    = 11;
  localparam int IDX_W    = 3;

  localparam logic [IDX_W-1:0] REG_IMAGE_ROWS  = 3'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_COLS  = 3'd1;
  localparam logic [IDX_W-1:0] REG_KERNEL_ROWS = 3'd2;
  localparam logic [IDX_W-1:0] REG_KERNEL_COLS = 3'd3;
  localparam logic [IDX_W-1:0] REG_OUT_MODE    = 3'd4;

  localparam logic [DIM_W-1:0] IMAGE_MAX = 11'd1024;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

  // control handed from the front of the pipeline to every cell
  typedef struct packed {
    logic                shift;
    logic                clear;
    logic                load;
    logic [TAP_W-1:0]    tap;
    logic [SAMPLE_W-1:0] coef;
  } cell_ctrl_t;

endpackage

@@ src/conv2d_full_or_same_unit.sv @@
// ----------------------------------------------------------------------------
// conv2d_full_or_same_unit
// streaming 2d convolution, full grid or centred same-size window
// ----------------------------------------------------------------------------
// pixel path: stage 0 register, window shift, column sums, output register
// throughput: one item per cycle; the pipeline stalls only on output backpressure
// line history lives in MAX_KERNEL-1 rams, one read and one write per cycle each
// reset (rst, synchronous): kernel taps zero, grid at row 0 column 0, registers
//   at 1 by 1 image and kernel, full mode; no ram clearing pass is needed
// ----------------------------------------------------------------------------
module conv2d_full_or_same_unit #(
  parameter int MAX_KERNEL = 5,
  parameter int MAX_LINE   = 1028
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // tap_index [4:0], sample [20:5], zero pad
  input  logic        s_tuser,   // command: 0 kernel load, 1 pixel
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // conv_value [35:0], zero pad
  output logic        m_tlast,   // last_out
  // configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int LAW = $clog2(MAX_LINE);
  localparam int KW  = $clog2(MAX_KERNEL + 1);
  localparam int SW  = c2d_pkg::SAMPLE_W;
  localparam int DW  = c2d_pkg::DIM_W;

  // raw registers
  logic [DW-1:0] image_rows, image_cols;
  logic [2:0]    kernel_rows, kernel_cols;
  logic          out_mode;

  // clamped and derived geometry
  logic [DW-1:0] r_n, c_n, h_last, w_last, rlo, rhi, clo, chi;
  logic [KW-1:0] k_n, l_n;
  logic [DW-1:0] r_n_next, c_n_next;
  logic [KW-1:0] k_n_next, l_n_next;

  // grid position
  logic [DW-1:0] grid_row, grid_col;

  // stage 0
  logic                        p0_valid, p0_pix, p0_inline, p0_clear, p0_emit, p0_last;
  logic [SW-1:0]               p0_x;
  logic [LAW-1:0]              p0_addr;
  logic [MAX_KERNEL-1:0]       p0_gate;
  logic [c2d_pkg::TAP_W-1:0]   p0_tap;
  logic [SW-1:0]               p0_coef;
  logic                        fwd_hit;
  logic [MAX_KERNEL-1:0][SW-1:0] fwd_col;

  // later stages
  logic p1_valid, p1_last, p2_valid, p2_last;

  logic                          en, accept, pix_in, ram_we;
  logic [LAW-1:0]                rd_addr;
  logic [MAX_KERNEL-1:0][SW-1:0] ram_q;
  logic [MAX_KERNEL-1:0][SW-1:0] col;
  logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][SW-1:0] cell_col;
  c2d_pkg::sum_t                 col_sum [MAX_KERNEL];
  c2d_pkg::sum_t                 total;
  c2d_pkg::cell_ctrl_t           ctrl;
  logic [MAX_KERNEL-1:0]         row_on;
  logic                          emit_now, last_now;

  // pipeline moves whenever the output register is free or being taken
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign accept   = s_tvalid && en;
  assign pix_in   = s_tuser;

  // configuration; any write restarts the grid
  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows  <= 11'd1;
      image_cols  <= 11'd1;
      kernel_rows <= 3'd1;
      kernel_cols <= 3'd1;
      out_mode    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        c2d_pkg::REG_IMAGE_ROWS:  image_rows  <= cfg_data;
        c2d_pkg::REG_IMAGE_COLS:  image_cols  <= cfg_data;
        c2d_pkg::REG_KERNEL_ROWS: kernel_rows <= cfg_data[2:0];
        c2d_pkg::REG_KERNEL_COLS: kernel_cols <= cfg_data[2:0];
        c2d_pkg::REG_OUT_MODE:    out_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // saturate registers into their legal ranges
  always_comb begin
    r_n_next = (image_rows == '0) ? DW'(1) :
               (image_rows > c2d_pkg::IMAGE_MAX) ? c2d_pkg::IMAGE_MAX : image_rows;
    c_n_next = (image_cols == '0) ? DW'(1) :
               (image_cols > c2d_pkg::IMAGE_MAX) ? c2d_pkg::IMAGE_MAX : image_cols;
    k_n_next = (kernel_rows == '0) ? KW'(1) :
               (32'(kernel_rows) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(kernel_rows);
    l_n_next = (kernel_cols == '0) ? KW'(1) :
               (32'(kernel_cols) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(kernel_cols);
  end

  // geometry follows the registers directly, so items may follow a write at once
  always_comb begin
    r_n    = r_n_next;
    c_n    = c_n_next;
    k_n    = k_n_next;
    l_n    = l_n_next;
    h_last = r_n + DW'(k_n) - DW'(2);
    w_last = c_n + DW'(l_n) - DW'(2);
    rlo    = DW'((k_n - KW'(1)) >> 1);
    clo    = DW'((l_n - KW'(1)) >> 1);
    rhi    = DW'((k_n - KW'(1)) >> 1) + r_n - DW'(1);
    chi    = DW'((l_n - KW'(1)) >> 1) + c_n - DW'(1);
  end

  // grid walk in raster order, wrapping at the frame end
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      grid_row <= '0;
      grid_col <= '0;
    end else if (accept && pix_in) begin
      if (grid_col == w_last) begin
        grid_col <= '0;
        grid_row <= (grid_row == h_last) ? '0 : grid_row + DW'(1);
      end else begin
        grid_col <= grid_col + DW'(1);
      end
    end
  end

  always_comb begin
    if (out_mode) begin
      emit_now = grid_row >= rlo && grid_row <= rhi && grid_col >= clo && grid_col <= chi;
      last_now = grid_row == rhi && grid_col == chi;
    end else begin
      emit_now = 1'b1;
      last_now = grid_row == h_last && grid_col == w_last;
    end
  end

  assign rd_addr = LAW'(grid_col);

  // stage 0: item registered, line history read
  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
    end else if (en) begin
      p0_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_pix    <= pix_in;
      p0_x      <= (grid_row < r_n && grid_col < c_n) ? s_tdata[20:5] : '0;
      p0_addr   <= rd_addr;
      p0_inline <= 32'(grid_col) < MAX_LINE;
      p0_clear  <= grid_col == '0;
      p0_emit   <= emit_now;
      p0_last   <= last_now;
      p0_tap    <= c2d_pkg::TAP_W'(s_tdata[4:0]);
      p0_coef   <= s_tdata[20:5];
      for (int a = 0; a < MAX_KERNEL; a++) begin
        p0_gate[a] <= (a == 0) ||
                      (32'(grid_col) < MAX_LINE && 32'(grid_row) >= a);
      end
      // same-column write in flight bypasses the ram
      fwd_hit <= ram_we && p0_addr == rd_addr;
      fwd_col <= col;
    end
  end

  assign ram_we = en && p0_valid && p0_pix && p0_inline;

  // row 0 has no stored history
  assign ram_q[0] = '0;

  // new window column: this row's pixel over the stored rows above
  always_comb begin
    col[0]   = p0_x;
    for (int a = 1; a < MAX_KERNEL; a++) begin
      col[a] = p0_gate[a] ? (fwd_hit ? fwd_col[a-1] : ram_q[a]) : '0;
    end
  end

  for (genvar a = 1; a < MAX_KERNEL; a++) begin : g_line
    c2d_ram #(
      .WIDTH(SW),
      .DEPTH(MAX_LINE)
    ) u_line (
      .clk  (clk),
      .we   (ram_we),
      .waddr(p0_addr),
      .wdata(col[a-1]),
      .re   (en),
      .raddr(rd_addr),
      .rdata(ram_q[a])
    );
  end

  always_comb begin
    ctrl.shift = p0_valid && p0_pix;
    ctrl.clear = p0_clear;
    ctrl.load  = p0_valid && !p0_pix &&
                 32'(p0_tap) < MAX_KERNEL * MAX_KERNEL;
    ctrl.tap   = p0_tap;
    ctrl.coef  = p0_coef;
    for (int a = 0; a < MAX_KERNEL; a++) begin
      row_on[a] = 32'(k_n) > a;
    end
  end

  // row of window cells; each hands its column to the next every shift
  for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_cell
    c2d_cell #(
      .MAX_KERNEL(MAX_KERNEL),
      .COL       (b)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .step   (en),
      .ctrl   (ctrl),
      .col_in ((b == 0) ? col : cell_col[(b == 0) ? 0 : b-1]),
      .col_out(cell_col[b]),
      .row_on (row_on),
      .col_on (32'(l_n) > b),
      .col_sum(col_sum[b])
    );
  end

  // stage 1 window shifted, stage 2 column sums ready
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      p1_valid <= p0_valid && p0_pix && p0_emit;
      p2_valid <= p1_valid;
      m_tvalid <= p2_valid;
    end
  end

  always_comb begin
    total = '0;
    for (int b = 0; b < MAX_KERNEL; b++) begin
      total = total + col_sum[b];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_last <= p0_last;
      p2_last <= p1_last;
      m_tlast <= p2_last;
      m_tdata <= {4'b0, total};
    end
  end

endmodule

@@ src/c2d_ram.sv @@
// ----------------------------------------------------------------------------
// c2d_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module c2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1028
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/c2d_cell.sv @@
// ----------------------------------------------------------------------------
// c2d_cell
// one window column: pixel column, kernel column and registered column sum
// ----------------------------------------------------------------------------
module c2d_cell #(
  parameter int MAX_KERNEL = 5,
  parameter int COL        = 0
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       step,
  input  c2d_pkg::cell_ctrl_t                        ctrl,
  input  logic [MAX_KERNEL-1:0][c2d_pkg::SAMPLE_W-1:0] col_in,
  output logic [MAX_KERNEL-1:0][c2d_pkg::SAMPLE_W-1:0] col_out,
  input  logic [MAX_KERNEL-1:0]                      row_on,
  input  logic                                       col_on,
  output c2d_pkg::sum_t                              col_sum
);

  logic [MAX_KERNEL-1:0][c2d_pkg::SAMPLE_W-1:0] pix;
  logic [MAX_KERNEL-1:0][c2d_pkg::SAMPLE_W-1:0] coef;
  c2d_pkg::sum_t                                sum_next;

  assign col_out = pix;

  // window column shift; all but the first cell clear at the start of each grid row
  always_ff @(posedge clk) begin
    if (step && ctrl.shift) begin
      if (ctrl.clear && COL != 0) begin
        pix <= '0;
      end else begin
        pix <= col_in;
      end
    end
  end

  // kernel taps of this column
  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (step && ctrl.load) begin
      for (int a = 0; a < MAX_KERNEL; a++) begin
        if (ctrl.tap == c2d_pkg::TAP_W'(a * MAX_KERNEL + COL)) begin
          coef[a] <= ctrl.coef;
        end
      end
    end
  end

  always_comb begin
    sum_next = '0;
    for (int a = 0; a < MAX_KERNEL; a++) begin
      if (row_on[a] && col_on) begin
        sum_next = sum_next + c2d_pkg::SUM_W'($signed(coef[a]) * $signed(pix[a]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      col_sum <= sum_next;
    end
  end

endmodule

@@ verif/tb_conv2d_full_or_same_unit.sv @@
// ----------------------------------------------------------------------------
// tb_conv2d_full_or_same_unit
// self-checking bench for the streaming 2d convolution unit: a queue-fed
// driver sends kernel loads and pixels, a behavioral predictor works out each
// convolution sum, and the monitor checks every result item in order
// ----------------------------------------------------------------------------
module tb_conv2d_full_or_same_unit;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int KMAX       = 5;
  localparam int LINE_LEN   = 1028;
  localparam int ITEM_GOAL  = 1750;
  localparam int STALL_MAX  = 3000;   // cycles with no item moving anywhere
  localparam int HOLD_LEN   = 300;    // long receiver hold-off
  localparam int DRAIN_WAIT = 12;     // pipeline is 4 deep, with margin

  // command codes carried on s_tuser
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  typedef struct {
    logic             cmd;
    logic [4:0]       tap;
    c2d_pkg::sample_t smp;
  } conv_item_t;

  typedef struct {
    logic [c2d_pkg::SUM_W-1:0] value;
    logic                      last;
  } conv_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // tap_index [4:0], sample [20:5], zero pad
  logic        s_tuser = 1'b0; // command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // conv_value [35:0], zero pad
  logic        m_tlast;        // last_out
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;

  always #6 clk = ~clk;

  conv2d_full_or_same_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  conv_item_t   pending_items[$];
  conv_result_t expected_sums[$];
  int           fail_count = 0;
  int           items_added = 0;
  int           send_idle_pct = 6;
  int           recv_idle_pct = 57;
  logic         hold_go = 1'b0;
  logic         hold_done = 1'b0;
  int           hold_left = 0;
  int           quiet_cycles = 0;

  // predictor state: registers as written, kernel, line history, window
  logic [10:0] pr_rows, pr_cols;
  logic [2:0]  pr_krows, pr_kcols;
  logic        pr_mode;
  int          pr_kernel[KMAX*KMAX];
  int          pr_hist[KMAX-1][LINE_LEN];
  int          pr_win[KMAX][KMAX];
  int          pr_row, pr_col;

  function automatic int clampi(input int v, input int lo, input int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // one pixel item: walk the grid, update history and window, push the sum
  task automatic convolve_pixel(input c2d_pkg::sample_t px);
    int r_n, c_n, k_n, l_n, h_n, w_n, gr, gc, r0, c0;
    int col_v[KMAX];
    longint acc;
    logic hit, fin;
    conv_result_t res;
    r_n = clampi(pr_rows, 1, 1024);
    c_n = clampi(pr_cols, 1, 1024);
    k_n = clampi(pr_krows, 1, KMAX);
    l_n = clampi(pr_kcols, 1, KMAX);
    h_n = r_n + k_n - 1;
    w_n = c_n + l_n - 1;
    gr = pr_row;
    gc = pr_col;
    if (gc >= w_n) gc = 0;
    if (gr >= h_n) gr = 0;
    // outside the image the pixel counts as zero
    col_v[0] = (gr < r_n && gc < c_n) ? int'(px) : 0;
    if (gc == 0) begin
      foreach (pr_win[a, b]) pr_win[a][b] = 0;
    end
    for (int a = 1; a < KMAX; a++)
      col_v[a] = (gc < LINE_LEN && a <= gr) ? pr_hist[a-1][gc] : 0;
    if (gc < LINE_LEN) begin
      for (int a = 1; a < KMAX; a++) pr_hist[a-1][gc] = col_v[a-1];
    end
    for (int a = 0; a < KMAX; a++) begin
      for (int b = KMAX - 1; b > 0; b--) pr_win[a][b] = pr_win[a][b-1];
      pr_win[a][0] = col_v[a];
    end
    acc = 0;
    for (int a = 0; a < k_n; a++)
      for (int b = 0; b < l_n; b++)
        acc += longint'(pr_kernel[a*KMAX+b]) * longint'(pr_win[a][b]);
    if (!pr_mode) begin
      hit = 1'b1;
      fin = (gr == h_n - 1 && gc == w_n - 1);
    end else begin
      r0 = (k_n - 1) / 2;
      c0 = (l_n - 1) / 2;
      hit = (gr >= r0 && gr < r0 + r_n && gc >= c0 && gc < c0 + c_n);
      fin = (gr == r0 + r_n - 1 && gc == c0 + c_n - 1);
    end
    gc++;
    if (gc >= w_n) begin
      gc = 0;
      gr++;
      if (gr >= h_n) gr = 0;
    end
    pr_row = gr;
    pr_col = gc;
    if (hit) begin
      res.value = acc[c2d_pkg::SUM_W-1:0];
      res.last  = fin;
      expected_sums.push_back(res);
    end
  endtask

  // driver: one nonblocking write per signal per edge
  always @(posedge clk) begin
    conv_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (s_tuser == CMD_PIXEL) convolve_pixel(c2d_pkg::sample_t'(s_tdata[20:5]));
        else if (s_tdata[4:0] < KMAX*KMAX)
          pr_kernel[s_tdata[4:0]] = int'(c2d_pkg::sample_t'(s_tdata[20:5]));
      end
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          it = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= it.cmd;
          s_tdata  <= {3'b000, it.smp, it.tap};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver backpressure, with one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: compare each result item with the oldest expected sum
  always @(posedge clk) begin
    conv_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_sums.size() == 0) begin
        $display("%0t unexpected result: got value %h last %b",
                 $realtime, m_tdata[c2d_pkg::SUM_W-1:0], m_tlast);
        fail_count++;
      end else begin
        want = expected_sums.pop_front();
        if (m_tdata[c2d_pkg::SUM_W-1:0] !== want.value) begin
          $display("%0t conv_value mismatch: expected %h actual %h",
                   $realtime, want.value, m_tdata[c2d_pkg::SUM_W-1:0]);
          fail_count++;
        end
        if (m_tlast !== want.last) begin
          $display("%0t last_out mismatch: expected %b actual %b",
                   $realtime, want.last, m_tlast);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // wait until the block has drained; loads leave no result, so pad after
  task automatic wait_drained();
    @(negedge clk);
    while (pending_items.size() > 0 || s_tvalid || expected_sums.size() > 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_regs(input int rows, input int cols, input int kr, input int kc,
                            input int mode);
    logic [2:0]  idx[5];
    logic [10:0] val[5];
    idx = '{c2d_pkg::REG_IMAGE_ROWS, c2d_pkg::REG_IMAGE_COLS, c2d_pkg::REG_KERNEL_ROWS,
            c2d_pkg::REG_KERNEL_COLS, c2d_pkg::REG_OUT_MODE};
    val = '{rows[10:0], cols[10:0], kr[10:0], kc[10:0], mode[10:0]};
    for (int i = 0; i < 5; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    // block is idle here, so the predictor takes the whole setting at once
    pr_rows  = rows[10:0];
    pr_cols  = cols[10:0];
    pr_krows = kr[2:0];
    pr_kcols = kc[2:0];
    pr_mode  = mode[0];
    pr_row   = 0;
    pr_col   = 0;
  endtask

  function automatic c2d_pkg::sample_t pick_sample(input bit corners);
    if (corners) return ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
    return c2d_pkg::sample_t'($urandom_range(65535));
  endfunction

  function automatic void add_item(input logic cmd, input int tap,
                                   input c2d_pkg::sample_t smp);
    conv_item_t it;
    it.cmd = cmd;
    it.tap = tap[4:0];
    it.smp = smp;
    pending_items.push_back(it);
    items_added++;
  endfunction

  initial begin
    int phase, rows, cols, kr, kc, mode, h_n, w_n, count;
    bit corners;
    pr_rows = 11'd1; pr_cols = 11'd1; pr_krows = 3'd1; pr_kcols = 3'd1; pr_mode = 1'b0;
    pr_row = 0; pr_col = 0;
    foreach (pr_kernel[i]) pr_kernel[i] = 0;
    foreach (pr_hist[a, b]) pr_hist[a][b] = 0;
    foreach (pr_win[a, b]) pr_win[a][b] = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: reset setting, extreme tap and pixel values, ignored tap index
    add_item(CMD_LOAD, 0, 16'sh8000);
    add_item(CMD_LOAD, 31, 16'sh1234);
    add_item(CMD_LOAD, 25, 16'sh7fff);
    add_item(CMD_PIXEL, 0, 16'sh8000);
    add_item(CMD_PIXEL, 0, 16'sh7fff);
    add_item(CMD_PIXEL, 0, 16'sh0000);
    add_item(CMD_PIXEL, 0, 16'shffff);
    wait_drained();

    // directed: same mode with an even kernel height, window edges and last
    write_regs(2, 2, 2, 3, 1);
    for (int t = 0; t < 6; t++) add_item(CMD_LOAD, (t / 3) * KMAX + t % 3, pick_sample(1));
    for (int p = 0; p < 12; p++) add_item(CMD_PIXEL, 0, pick_sample(1));
    wait_drained();

    phase = 0;
    while (items_added < ITEM_GOAL) begin
      if (items_added > 2 * ITEM_GOAL / 3) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end else if (items_added > ITEM_GOAL / 3) begin
        send_idle_pct = 57; recv_idle_pct = 6;
      end
      corners = 1'b0;
      case (phase)
        0: begin rows = 1024; cols = 1024; kr = 5; kc = 5; mode = 0; corners = 1'b1; end
        1: begin rows = 1024; cols = 1024; kr = 5; kc = 5; mode = 1; end
        2: begin rows = 0; cols = 2047; kr = 0; kc = 7; mode = 1; end
        3: begin rows = 1; cols = 1; kr = 1; kc = 1; mode = 0; end
        4: begin rows = 2047; cols = 0; kr = 6; kc = 0; mode = 0; end
        default: begin
          rows = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(8);
          cols = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(8);
          kr = $urandom_range(7);
          kc = $urandom_range(7);
          mode = $urandom_range(1);
          corners = ($urandom_range(7) == 0);
        end
      endcase
      write_regs(rows, cols, kr, kc, mode);
      for (int t = 0; t < KMAX * KMAX; t++) add_item(CMD_LOAD, t, pick_sample(corners));
      if ($urandom_range(3) == 0) add_item(CMD_LOAD, $urandom_range(31), pick_sample(0));
      h_n = clampi(rows, 1, 1024) + clampi(kr, 1, KMAX) - 1;
      w_n = clampi(cols, 1, 1024) + clampi(kc, 1, KMAX) - 1;
      // a few whole frames to cover wrap-around, partial frames on big grids
      count = h_n * w_n * $urandom_range(1, 3) + $urandom_range(3);
      if (count > 160) count = 160;
      for (int p = 0; p < count; p++) begin
        if ($urandom_range(39) == 0) add_item(CMD_LOAD, $urandom_range(31), pick_sample(0));
        add_item(CMD_PIXEL, $urandom_range(31), pick_sample(corners));
      end
      // long receiver hold-off while the queue keeps offering items
      if (phase == 1) hold_go <= 1'b1;
      // sender pauses until every expected result has arrived
      wait_drained();
      phase++;
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
